### hw/rtl/gb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb_pkg
// Shared types, constants and kernel functions of the Gaussian blur unit.
// ----------------------------------------------------------------------------
package gb_pkg;

    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int POSX_W     = 10;
    localparam int POSY_W     = 12;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix;

    typedef struct packed {
        logic [POSX_W-1:0] pos_x;
        logic [POSY_W-1:0] pos_y;
        logic [7:0]        red_out;
        logic [7:0]        green_out;
        logic [7:0]        blue_out;
        logic              is_filtered;
        logic              last_of_run;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg;

    typedef struct packed {
        logic [POSX_W-1:0] pass_x;
        logic [POSY_W-1:0] pass_y;
        logic [POSX_W-1:0] filt_x;
        logic [POSY_W-1:0] filt_y;
        t_pix              pix;
        logic              do_filt;
        logic              do_pass;
    } t_job_meta;

    // exp(-d/50) in q32 by alternating series
    function automatic logic [63:0] gb_weight(logic [63:0] d);
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        t   = 64'd1 << 32;
        pos = t;
        neg = 64'd0;
        for (int k = 1; k < 20; k++) begin
            t = (t * d) / 64'(50 * k);
            if ((k % 2) == 1) neg = neg + t;
            else pos = pos + t;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    // unnormalized weight of one window tap
    function automatic logic [63:0] gb_tap_weight(int ks, int idx);
        logic [63:0] wt;
        int c0;
        int ox;
        int oy;
        c0 = ks - 1 - ks / 2;
        wt = 64'd0;
        for (int r = 0; r < ks; r++) begin
            for (int c = 0; c < ks; c++) begin
                if (r * ks + c == idx) begin
                    oy = r - c0;
                    ox = c - c0;
                    wt = gb_weight(64'(ox * ox + oy * oy));
                end
            end
        end
        return wt;
    endfunction

    function automatic logic [63:0] gb_weight_total(int ks);
        logic [63:0] total;
        total = 64'd0;
        for (int t = 0; t < ks * ks; t++) total = total + gb_tap_weight(ks, t);
        return total;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/gb_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb_ifs
// Handshake channels of the Gaussian blur unit: pixels, results, config.
// ----------------------------------------------------------------------------
interface gb_pix_if import gb_pkg::*; ();
    logic valid;
    logic ready;
    t_pix data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gb_res_if import gb_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gb_cfg_if import gb_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/gb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/gb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb_queue
// Short register queue between front and back, with fill count.
// ----------------------------------------------------------------------------
module gb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic                            o_valid,
    output logic [WIDTH-1:0]                o_data,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [NW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_data;
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rp];
    assign o_count = r_cnt;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != NW'(DEPTH)) || i_pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0)) else $error("queue underflow");
endmodule
`default_nettype wire

### hw/rtl/gb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb_front
// Raster counters, config, line stores and window; classifies each item.
// ----------------------------------------------------------------------------
module gb_front import gb_pkg::*; #(
    parameter int KERNEL_SIZE = 5,
    parameter int MAX_WIDTH   = 1024,
    parameter int QDEPTH      = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    gb_pix_if.sink                               i_pix,
    gb_cfg_if.sink                               i_cfg,
    input  wire logic [$clog2(QDEPTH+1)-1:0]     i_q_count,
    output logic                                 o_push,
    output t_job_meta                            o_meta,
    output logic [KERNEL_SIZE*KERNEL_SIZE*PIX_W-1:0] o_window
);
    localparam int H     = KERNEL_SIZE / 2;
    localparam int LINES = KERNEL_SIZE - 1;
    localparam int TAPS  = KERNEL_SIZE * KERNEL_SIZE;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW    = XW + 2;
    localparam int QCW   = $clog2(QDEPTH + 1);
    localparam int WRST  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    logic [XW-1:0]       r_x;
    logic [POSY_W-1:0]   r_y;
    logic [XW:0]         r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic                r_fv;
    logic [XW-1:0]       r_fx;
    t_job_meta           r_meta;
    logic                r_byp;
    logic [PIX_W-1:0]    r_bd  [LINES];
    logic [PIX_W-1:0]    r_win [TAPS];
    logic [PIX_W-1:0]    w_q   [LINES];
    logic [PIX_W-1:0]    col   [KERNEL_SIZE];
    logic [PIX_W-1:0]    n_win [TAPS];
    logic                acc;
    logic                cfg_acc;
    logic [WIDTH_W-1:0]  cw;
    logic                do_filt;
    logic                do_pass;
    logic                last_col;
    logic                last_row;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;
    assign cw          = i_cfg.data.value[WIDTH_W-1:0];

    assign i_pix.ready = ({1'b0, i_q_count} + (QCW+1)'(r_fv)) < (QCW+1)'(QDEPTH);
    assign acc         = i_pix.valid && i_pix.ready;

    assign do_filt  = (r_x >= XW'(2 * H)) && (r_y >= POSY_W'(2 * H));
    assign do_pass  = (r_x < XW'(H)) || (r_y < POSY_W'(H))
                   || ((CW'(r_x) + CW'(H)) >= CW'(r_width))
                   || (({1'b0, r_y} + 13'(H)) >= {1'b0, r_height});
    assign last_col = (CW'(r_x) + CW'(1)) >= CW'(r_width);
    assign last_row = ({1'b0, r_y} + 13'd1) >= {1'b0, r_height};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_width  <= (XW+1)'(WRST);
            r_height <= HEIGHT_W'(1024);
            r_fv     <= 1'b0;
        end else begin
            r_fv <= acc;
            if (cfg_acc) begin
                unique case (i_cfg.data.index)
                    CFG_IMAGE_WIDTH: begin
                        if (cw == '0) r_width <= (XW+1)'(1);
                        else if (int'(cw) > MAX_WIDTH) r_width <= (XW+1)'(MAX_WIDTH);
                        else r_width <= (XW+1)'(cw);
                        r_x <= '0;
                        r_y <= '0;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_height <= (i_cfg.data.value == '0) ? HEIGHT_W'(1)
                                                             : i_cfg.data.value;
                        r_x <= '0;
                        r_y <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (acc) begin
                if (last_col) begin
                    r_x <= '0;
                    r_y <= last_row ? '0 : r_y + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_fx           <= r_x;
            r_meta.pass_x  <= POSX_W'(r_x);
            r_meta.pass_y  <= r_y;
            r_meta.filt_x  <= POSX_W'(r_x - XW'(H));
            r_meta.filt_y  <= r_y - POSY_W'(H);
            r_meta.pix     <= i_pix.data;
            r_meta.do_filt <= do_filt;
            r_meta.do_pass <= do_pass;
            r_byp          <= r_fv && (r_fx == r_x);
            for (int r = 0; r < LINES; r++) r_bd[r] <= col[r + 1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < LINES; g++) begin : g_line
            gb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
                .i_clk   (i_clk),
                .i_we    (r_fv),
                .i_waddr (r_fx),
                .i_wdata (col[g + 1]),
                .i_re    (acc),
                .i_raddr (r_x),
                .o_rdata (w_q[g])
            );
        end
    endgenerate

    always_comb begin
        for (int r = 0; r < LINES; r++) col[r] = r_byp ? r_bd[r] : w_q[r];
        col[LINES] = r_meta.pix;
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE - 1; c++)
                n_win[r * KERNEL_SIZE + c] = r_win[r * KERNEL_SIZE + c + 1];
            n_win[r * KERNEL_SIZE + KERNEL_SIZE - 1] = col[r];
        end
        for (int t = 0; t < TAPS; t++) o_window[t * PIX_W +: PIX_W] = n_win[t];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAPS; t++) r_win[t] <= '0;
        end else if (r_fv) begin
            for (int t = 0; t < TAPS; t++) r_win[t] <= n_win[t];
        end
    end

    assign o_push = r_fv;
    assign o_meta = r_meta;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv |-> (i_q_count < QCW'(QDEPTH))) else $error("push without room");
endmodule
`default_nettype wire

### hw/rtl/gb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb_back
// Weighted window sum per color and result sequencing into the output register.
// ----------------------------------------------------------------------------
module gb_back import gb_pkg::*; #(
    parameter int KERNEL_SIZE    = 5,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_pop,
    input  wire t_job_meta                             i_meta,
    input  wire logic [KERNEL_SIZE*KERNEL_SIZE*PIX_W-1:0] i_window,
    gb_res_if.source                                   o_res
);
    localparam int TAPS = KERNEL_SIZE * KERNEL_SIZE;
    localparam int CB   = COEF_FRAC_BITS + 1;
    localparam int PW   = CB + 8;
    localparam int RW   = PW + $clog2(KERNEL_SIZE);
    localparam int SW   = PW + $clog2(TAPS);
    localparam int QW   = SW - COEF_FRAC_BITS;
    localparam logic [63:0] W_TOTAL = gb_weight_total(KERNEL_SIZE);

    logic [CB-1:0] w_coef [TAPS];

    genvar g;
    generate
        for (g = 0; g < TAPS; g++) begin : g_coef
            localparam logic [63:0] W_TAP = gb_tap_weight(KERNEL_SIZE, g);
            localparam logic [63:0] COEF =
                ((W_TAP << COEF_FRAC_BITS) + (W_TOTAL >> 1)) / W_TOTAL;
            assign w_coef[g] = COEF[CB-1:0];
        end
    endgenerate

    logic          r_v1, r_v2, r_v3;
    t_job_meta     r_m1, r_m2, r_m3;
    logic [PW-1:0] r_p1 [3][TAPS];
    logic [RW-1:0] r_s2 [3][KERNEL_SIZE];
    logic [7:0]    r_c3 [3];
    logic [RW-1:0] row_sum [3][KERNEL_SIZE];
    logic [SW-1:0] tot [3];
    logic [QW-1:0] qv [3];
    logic          adv;
    logic          done3;
    logic          emit;
    logic          out_free;
    logic          r_first;
    logic          n_first;
    logic          r_out_valid;
    t_res          r_out;
    t_res          res;

    assign out_free = !r_out_valid || o_res.ready;
    assign adv      = !r_v3 || done3;
    assign o_pop    = i_valid && adv;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                row_sum[ch][r] = '0;
                for (int c = 0; c < KERNEL_SIZE; c++)
                    row_sum[ch][r] = row_sum[ch][r] + RW'(r_p1[ch][r * KERNEL_SIZE + c]);
            end
            tot[ch] = '0;
            for (int r = 0; r < KERNEL_SIZE; r++) tot[ch] = tot[ch] + SW'(r_s2[ch][r]);
            qv[ch] = tot[ch][SW-1:COEF_FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1 <= i_meta;
            r_m2 <= r_m1;
            r_m3 <= r_m2;
            for (int ch = 0; ch < 3; ch++) begin
                for (int t = 0; t < TAPS; t++)
                    r_p1[ch][t] <= PW'(w_coef[t] * i_window[t * PIX_W + 16 - 8 * ch +: 8]);
                for (int r = 0; r < KERNEL_SIZE; r++) r_s2[ch][r] <= row_sum[ch][r];
                r_c3[ch] <= (qv[ch] > QW'(255)) ? 8'd255 : qv[ch][7:0];
            end
        end
    end

    always_comb begin
        emit    = 1'b0;
        done3   = 1'b0;
        n_first = r_first;
        res     = '0;
        if (r_v3) begin
            if (!r_m3.do_filt && !r_m3.do_pass) begin
                done3 = 1'b1;
            end else if (out_free) begin
                emit = 1'b1;
                if (r_m3.do_filt && !r_first) begin
                    res.pos_x       = r_m3.filt_x;
                    res.pos_y       = r_m3.filt_y;
                    res.red_out     = r_c3[0];
                    res.green_out   = r_c3[1];
                    res.blue_out    = r_c3[2];
                    res.is_filtered = 1'b1;
                    res.last_of_run = !r_m3.do_pass;
                    if (r_m3.do_pass) n_first = 1'b1;
                    else done3 = 1'b1;
                end else begin
                    res.pos_x       = r_m3.pass_x;
                    res.pos_y       = r_m3.pass_y;
                    res.red_out     = r_m3.pix.red_in;
                    res.green_out   = r_m3.pix.green_in;
                    res.blue_out    = r_m3.pix.blue_in;
                    res.is_filtered = 1'b0;
                    res.last_of_run = 1'b1;
                    done3           = 1'b1;
                    n_first         = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_first <= n_first;
            if (out_free) r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= res;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    a_first_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first |-> r_v3 && r_m3.do_filt && r_m3.do_pass)
        else $error("pending second result without a two-result item");
    a_first_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_first) |-> r_out_valid && r_out.is_filtered && !r_out.last_of_run)
        else $error("first of two results not filtered");
endmodule
`default_nettype wire

### hw/rtl/gaussian_blur_rgb_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_blur_rgb_unit
// Gaussian blur over an RGB raster stream with line stores and a square window.
// ----------------------------------------------------------------------------
// i_pix takes one RGB pixel per item in raster order; o_res gives results
// with coordinates, an is_filtered flag and last_of_run on the final result
// of each input item. i_cfg writes image_width (index 0) and image_height
// (index 1); each write restarts the frame at column 0, row 0.
// Throughput: one pixel per cycle while the queue has room; a pixel that
// yields both a window result and a border pass-through stalls the back end
// until its second result is taken. From pixel accept, a result passes
// through line-store read with window update into the queue, multiply,
// row sum, total and saturate, and the output register.
// Reset clears counters, the window and all valid flags; width returns to
// the smaller of MAX_WIDTH and 1024 and height to 1024. Line stores are not
// cleared; entries are written before use within a frame.
// When o_res stalls, results back up through the back end and queue; i_pix
// ready drops once the queue, with the push in flight, would be full.
// ----------------------------------------------------------------------------
module gaussian_blur_rgb_unit import gb_pkg::*; #(
    parameter int KERNEL_SIZE    = 5,
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gb_pix_if.sink    i_pix,
    gb_cfg_if.sink    i_cfg,
    gb_res_if.source  o_res
);
    localparam int QDEPTH = 4;
    localparam int WIN_W  = KERNEL_SIZE * KERNEL_SIZE * PIX_W;
    localparam int MW     = $bits(t_job_meta);
    localparam int JW     = MW + WIN_W;

    logic                          push;
    logic                          pop;
    logic                          q_valid;
    t_job_meta                     f_meta;
    logic [WIN_W-1:0]              f_win;
    logic [JW-1:0]                 q_data;
    logic [$clog2(QDEPTH+1)-1:0]   q_count;

    gb_front #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH),
        .QDEPTH      (QDEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_cfg     (i_cfg),
        .i_q_count (q_count),
        .o_push    (push),
        .o_meta    (f_meta),
        .o_window  (f_win)
    );

    gb_queue #(.WIDTH(JW), .DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_meta, f_win}),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    gb_back #(
        .KERNEL_SIZE    (KERNEL_SIZE),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (pop),
        .i_meta   (t_job_meta'(q_data[JW-1:WIN_W])),
        .i_window (q_data[WIN_W-1:0]),
        .o_res    (o_res)
    );
endmodule
`default_nettype wire
